FILE: rtl/dscp_pkg.sv
// Shared types, constants and helpers for the diagonal scaling preconditioner.
package dscp_pkg;

  localparam int ROWS_DEFAULT = 1024;
  localparam int ROW_W        = 10;
  localparam int VALUE_W      = 64;
  localparam int THRESH_W     = 63;
  localparam int CFG_INDEX_W  = 1;
  localparam int CNT_W        = 7;

  localparam logic [0:0] OP_LOAD  = 1'b0;
  localparam logic [0:0] OP_APPLY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT = 1'b1;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 63'd42950;
  localparam logic [VALUE_W-1:0]  REPLACEMENT_RESET = 64'd4724464026;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // 2^64 / m takes one quotient bit per step, 65 steps in all
  localparam logic [CNT_W-1:0] DIV_LAST = 7'd64;
  // four partial products, the last one added one step later
  localparam logic [CNT_W-1:0] MUL_LAST = 7'd4;

  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       div_step;
    logic       div_lead;
    logic       table_write;
    logic       table_read;
    logic       scale_load;
    logic       acc_clear;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       acc_add;
    logic       out_load;
  } dscp_cmd_t;

  typedef struct packed {
    logic is_apply;
    logic need_recip;
    logic out_free;
  } dscp_status_t;

  function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
    magnitude = v[VALUE_W-1] ? (~v + 64'd1) : v;
  endfunction

endpackage

FILE: rtl/diagonal_scaling_preconditioner.sv
// Top level of the Jacobi diagonal scaling preconditioner (signed Q32.32).
//
// Input channel (in_valid/in_ready): operation, row_index, operand_value.
//   A load item (operation 0) stores a row scale: the reciprocal of the
//   diagonal when its magnitude exceeds the threshold register, else the
//   replacement register. It gives no result.
//   An apply item (operation 1) returns operand_value times the row scale.
// Output channel (out_valid/out_ready): result_row, scaled_value, saturated.
// Config port: cfg_we, cfg_index (0 threshold, 1 replacement), cfg_data.
// One item is worked at a time; in_ready is high only when the sequencer is free.
//   Load with reciprocal: runs the 65-step bit-serial divider, then writes the table.
//   Load with replacement: writes the table without the divider.
//   Apply: reads the table, then takes four steps of the shared 32x32 multiplier;
//   out_valid rises after the final accumulate, once the result register is free.
// The result register holds the item while out_ready is low; the next item
// can be taken meanwhile, and a finished apply waits until the register frees.
// Reset restores both config registers and empties the pipeline. The scale
// table is not cleared: apply only to rows that were loaded.
module diagonal_scaling_preconditioner #(
  parameter int ROWS = dscp_pkg::ROWS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dscp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dscp_pkg::VALUE_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic [dscp_pkg::ROW_W-1:0]          row_index,
  input  logic signed [dscp_pkg::VALUE_W-1:0] operand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dscp_pkg::ROW_W-1:0]          result_row,
  output logic signed [dscp_pkg::VALUE_W-1:0] scaled_value,
  output logic                                saturated
);
  import dscp_pkg::*;

  dscp_cmd_t    cmd;
  dscp_status_t status;

  dscp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dscp_datapath #(
    .ROWS (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .row_index     (row_index),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_row    (result_row),
    .scaled_value  (scaled_value),
    .saturated     (saturated),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

FILE: rtl/dscp_ctrl.sv
// Sequencer for load and apply items: divider steps, table access, multiply steps.
module dscp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dscp_pkg::dscp_status_t status,
  output dscp_pkg::dscp_cmd_t    cmd
);
  import dscp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_READ  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (status.is_apply) begin
          cmd.table_read = 1'b1;
          state_next     = S_READ;
        end else if (status.need_recip) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_lead = (cnt == '0);
        cnt_next     = cnt + 7'd1;
        if (cnt == DIV_LAST) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.table_write = 1'b1;
        state_next      = S_IDLE;
      end
      S_READ: begin
        cmd.scale_load = 1'b1;
        cmd.acc_clear  = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        // product of step n is added at step n+1
        cmd.mul_step = (cnt != MUL_LAST);
        cmd.mul_sel  = cnt[1:0];
        cmd.acc_add  = (cnt != '0);
        cnt_next     = cnt + 7'd1;
        if (cnt == MUL_LAST) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register loaded while occupied");

  a_write_only_load: assert property (@(posedge clk) disable iff (rst)
    cmd.table_write |-> !status.is_apply)
    else $error("scale table written for an apply item");

  a_div_ends_in_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == DIV_LAST) |=> cmd.table_write)
    else $error("divider finished without a table write");
`endif

endmodule

FILE: rtl/dscp_datapath.sv
// Config registers, scale table, shared reciprocal divider, multiplier and result register.
module dscp_datapath #(
  parameter int ROWS = dscp_pkg::ROWS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dscp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dscp_pkg::VALUE_W-1:0]      cfg_data,
  input  logic                              operation,
  input  logic [dscp_pkg::ROW_W-1:0]        row_index,
  input  logic signed [dscp_pkg::VALUE_W-1:0] operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dscp_pkg::ROW_W-1:0]        result_row,
  output logic signed [dscp_pkg::VALUE_W-1:0] scaled_value,
  output logic                              saturated,
  input  dscp_pkg::dscp_cmd_t               cmd,
  output dscp_pkg::dscp_status_t            status
);
  import dscp_pkg::*;

  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXT_W  = (ADDR_W > ROW_W) ? ADDR_W : ROW_W;

  logic [THRESH_W-1:0] threshold;
  logic [VALUE_W-1:0]  replacement;

  logic               op_q;
  logic [ROW_W-1:0]   row_q;
  logic               row_ok;
  logic               a_sign;
  logic [VALUE_W-1:0] a_mag;

  logic [VALUE_W-1:0] scale_mem [ROWS];
  logic [VALUE_W-1:0] rd_data;
  logic [EXT_W-1:0]   row_ext;
  logic [ADDR_W-1:0]  addr;

  logic [VALUE_W-1:0] rem;
  logic [VALUE_W:0]   quot;
  logic [VALUE_W:0]   trial;
  logic               trial_ge;
  logic [VALUE_W-1:0] recip;
  logic [VALUE_W-1:0] table_wdata;

  logic               b_sign;
  logic [VALUE_W-1:0] b_mag;
  logic [31:0]        a_half, b_half;
  logic [VALUE_W-1:0] pp;
  logic [1:0]         pp_sel;
  logic [127:0]       addend;
  logic [127:0]       acc;

  logic               p_neg;
  logic [VALUE_W-1:0] p_mag;
  logic [VALUE_W-1:0] p_value;
  logic               p_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      replacement <= REPLACEMENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:   threshold   <= cfg_data[THRESH_W-1:0];
        CFG_REPLACEMENT: replacement <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      row_q  <= row_index;
      row_ok <= (32'(row_index) < 32'(ROWS));
      a_sign <= operand_value[VALUE_W-1];
      a_mag  <= magnitude(operand_value);
    end
  end

  assign status.is_apply   = (op_q == OP_APPLY);
  assign status.need_recip = (a_mag > {1'b0, threshold});
  assign status.out_free   = !out_valid || out_ready;

  // restoring division of 2^64 by a_mag
  assign trial    = {rem, cmd.div_lead};
  assign trial_ge = (trial >= {1'b0, a_mag});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? VALUE_W'(trial - {1'b0, a_mag}) : trial[VALUE_W-1:0];
      quot <= {quot[VALUE_W-1:0], trial_ge};
    end
  end

  always_comb begin
    if (a_sign) begin
      recip = (quot[VALUE_W:VALUE_W-1] != 2'b00) ? NEG_LIMIT : (~quot[VALUE_W-1:0] + 64'd1);
    end else begin
      recip = (quot[VALUE_W:VALUE_W-1] != 2'b00) ? POS_LIMIT : quot[VALUE_W-1:0];
    end
  end

  assign table_wdata = status.need_recip ? recip : replacement;

  // scale table
  assign row_ext = EXT_W'(row_q);
  assign addr    = row_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.table_write && row_ok) begin
      scale_mem[addr] <= table_wdata;
    end
    if (cmd.table_read) begin
      rd_data <= scale_mem[addr];
    end
  end

  // out-of-range rows scale by zero
  always_ff @(posedge clk) begin
    if (cmd.scale_load) begin
      b_sign <= row_ok & rd_data[VALUE_W-1];
      b_mag  <= row_ok ? magnitude(rd_data) : '0;
    end
  end

  // 64x64 magnitude product from four 32x32 partial products
  assign a_half = cmd.mul_sel[1] ? a_mag[63:32] : a_mag[31:0];
  assign b_half = cmd.mul_sel[0] ? b_mag[63:32] : b_mag[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      pp     <= VALUE_W'(a_half * b_half);
      pp_sel <= cmd.mul_sel;
    end
  end

  always_comb begin
    case (pp_sel) inside
      PP_LL:        addend = {64'd0, pp};
      PP_LH, PP_HL: addend = {32'd0, pp, 32'd0};
      PP_HH:        addend = {pp, 64'd0};
      default:      addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + addend;
    end
  end

  // drop 32 fraction bits, then sign and clip
  assign p_neg = a_sign ^ b_sign;
  assign p_mag = acc[95:32];

  always_comb begin
    p_sat   = 1'b0;
    p_value = p_mag;
    if (acc[127:96] != '0) begin
      p_sat   = 1'b1;
      p_value = p_neg ? NEG_LIMIT : POS_LIMIT;
    end else if (p_neg) begin
      if (p_mag > NEG_LIMIT) begin
        p_sat   = 1'b1;
        p_value = NEG_LIMIT;
      end else begin
        p_value = ~p_mag + 64'd1;
      end
    end else if (p_mag[VALUE_W-1]) begin
      p_sat   = 1'b1;
      p_value = POS_LIMIT;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_row   <= row_q;
      scaled_value <= p_value;
      saturated    <= p_sat;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < a_mag))
    else $error("divider remainder not below divisor");

  a_sat_is_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (scaled_value == NEG_LIMIT || scaled_value == POS_LIMIT))
    else $error("saturated result is not a range limit");
`endif

endmodule

FILE: test/diagonal_scaling_preconditioner_tb.sv
// Self-checking testbench for the diagonal scaling preconditioner: loads and applies with a scale predictor.
module diagonal_scaling_preconditioner_tb;
  import dscp_pkg::*;

  localparam int TABLE_ROWS  = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYC  = 100;
  localparam int SEG_ITEMS   = 288;
  localparam int HOLD_CYC    = 400;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [VALUE_W-1:0] value;
    logic               clipped;
  } scaled_rhs_t;

  class rhs_scaling_board;
    logic [THRESH_W-1:0] pivot_floor;
    logic [VALUE_W-1:0]  fallback_scale;
    logic [VALUE_W-1:0]  row_scale [TABLE_ROWS];
    scaled_rhs_t         awaited[$];
    int                  errors;

    function new();
      pivot_floor    = THRESHOLD_RESET;
      fallback_scale = REPLACEMENT_RESET;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:   pivot_floor = data[THRESH_W-1:0];
        CFG_REPLACEMENT: fallback_scale = data;
        default: ;
      endcase
    endfunction

    function logic [VALUE_W-1:0] abs64(logic [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? -v : v;
    endfunction

    // 2^64 / |v| truncated, signed like v, clipped to the 64-bit range
    function logic [VALUE_W-1:0] recip_q32(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] m;
      logic [VALUE_W:0]   q;
      m = abs64(v);
      if (m <= 64'd1) return v[VALUE_W-1] ? NEG_LIMIT : POS_LIMIT;
      q = {1'b1, {VALUE_W{1'b0}}} / {1'b0, m};
      if (v[VALUE_W-1]) return -q[VALUE_W-1:0];
      return (q[VALUE_W-1:0] > POS_LIMIT) ? POS_LIMIT : q[VALUE_W-1:0];
    endfunction

    function scaled_rhs_t scale_rhs(logic [ROW_W-1:0] row, logic [VALUE_W-1:0] rhs);
      scaled_rhs_t        r;
      logic               neg;
      logic [127:0]       p;
      logic [VALUE_W-1:0] m;
      neg       = rhs[VALUE_W-1] ^ row_scale[row][VALUE_W-1];
      p         = {64'd0, abs64(rhs)} * {64'd0, abs64(row_scale[row])};
      m         = p[95:32];
      r.row     = row;
      r.clipped = 1'b0;
      if (p[127:96] != 0) begin
        r.clipped = 1'b1;
        r.value   = neg ? NEG_LIMIT : POS_LIMIT;
      end else if (neg) begin
        r.clipped = (m > NEG_LIMIT);
        r.value   = r.clipped ? NEG_LIMIT : -m;
      end else begin
        r.clipped = (m > POS_LIMIT);
        r.value   = r.clipped ? POS_LIMIT : m;
      end
      return r;
    endfunction

    function void note_item(logic op, logic [ROW_W-1:0] row, logic [VALUE_W-1:0] v);
      if (op == OP_LOAD) begin
        if (abs64(v) > {1'b0, pivot_floor}) row_scale[row] = recip_q32(v);
        else row_scale[row] = fallback_scale;
      end else begin
        awaited.push_back(scale_rhs(row, v));
      end
    endfunction

    function void check_result(logic [ROW_W-1:0] row, logic [VALUE_W-1:0] v, logic sat);
      scaled_rhs_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result row %0d value %h saturated %b", $time, row, v, sat);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (row !== e.row) begin
        $display("%0t: result_row expected %0d got %0d", $time, e.row, row);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: scaled_value expected %h got %h", $time, e.value, v);
        errors++;
      end
      if (sat !== e.clipped) begin
        $display("%0t: saturated expected %b got %b", $time, e.clipped, sat);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = CFG_THRESHOLD;
  logic [VALUE_W-1:0]            cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          operation = OP_LOAD;
  logic [ROW_W-1:0]              row_index = '0;
  logic signed [VALUE_W-1:0]     operand_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ROW_W-1:0]              result_row;
  logic signed [VALUE_W-1:0]     scaled_value;
  logic                          saturated;

  rhs_scaling_board board = new();
  int               send_idle = 0;
  int               recv_idle = 0;
  bit               stall_req = 1'b0;
  int               hold_left = 0;
  int               cycles = 0;
  bit               row_loaded [TABLE_ROWS];
  logic [ROW_W-1:0] loaded_rows[$];
  logic [ROW_W-1:0] last_loaded = '0;

  diagonal_scaling_preconditioner DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row_index(row_index), .operand_value(operand_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_row(result_row), .scaled_value(scaled_value), .saturated(saturated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check at the rising edge, pick ready at the falling edge
  always begin
    @(posedge clk);
    if (!rst && out_valid && out_ready)
      board.check_result(result_row, scaled_value, saturated);
    @(negedge clk);
    if (stall_req) begin
      hold_left = HOLD_CYC;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value(logic [THRESH_W-1:0] floor_val);
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: begin
        // straddle the pivot threshold
        v = {1'b0, floor_val} + $urandom_range(0, 4) - 64'd2;
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = POS_LIMIT;
          1: v = NEG_LIMIT;
          2: v = '0;
          3: v = 64'd1;
          default: v = '1;
        endcase
      end
      default: v = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic send_item(logic op, logic [ROW_W-1:0] row, logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    row_index     <= row;
    operand_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_item(op, row, v);
  endtask

  task automatic load_row(logic [ROW_W-1:0] row, logic [VALUE_W-1:0] v);
    if (!row_loaded[row]) begin
      row_loaded[row] = 1'b1;
      loaded_rows.push_back(row);
    end
    last_loaded = row;
    send_item(OP_LOAD, row, v);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // Drop valid, drain results, then cover a trailing reciprocal load
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic random_item();
    logic [ROW_W-1:0]   r;
    logic [VALUE_W-1:0] v;
    v = pick_value(board.pivot_floor);
    if (loaded_rows.size() == 0 || $urandom_range(0, 99) < 35) begin
      r = ROW_W'($urandom_range(0, TABLE_ROWS - 1));
      load_row(r, v);
    end else begin
      r = ($urandom_range(0, 99) < 40) ? last_loaded
                                         : loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
      send_item(OP_APPLY, r, v);
    end
  endtask

  task automatic run_segment(int s_idle, int r_idle, logic [VALUE_W-1:0] thr,
                             logic [VALUE_W-1:0] rep, bit stall);
    send_idle = s_idle;
    recv_idle = r_idle;
    write_cfg(CFG_THRESHOLD, thr);
    write_cfg(CFG_REPLACEMENT, rep);
    if (stall) stall_req = 1'b1;
    repeat (SEG_ITEMS) random_item();
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 14;
    recv_idle = 55;
    load_row(10'd0, 64'd1);
    load_row(10'd1, '1);
    load_row(10'd2, 64'd2);
    load_row(10'd3, 64'hFFFF_FFFF_FFFF_FFFE);
    load_row(10'd4, NEG_LIMIT);
    load_row(10'd5, POS_LIMIT);
    load_row(10'd6, 64'd0);
    load_row(10'd7, 64'd42950);
    load_row(10'd8, -64'd42951);
    load_row(10'd1023, 64'h0000_0001_0000_0000);
    load_row(10'd9, 64'hFFFF_FFFF_0000_0000);
    load_row(10'd10, 64'h0000_0000_8000_0000);
    send_item(OP_APPLY, 10'd1023, NEG_LIMIT);
    send_item(OP_APPLY, 10'd9, NEG_LIMIT);
    send_item(OP_APPLY, 10'd0, 64'h0000_0001_0000_0000);
    send_item(OP_APPLY, 10'd0, 64'h0000_0001_0000_0001);
    send_item(OP_APPLY, 10'd3, 64'h0000_0001_0000_0000);
    send_item(OP_APPLY, 10'd1, 64'hFFFF_FFFF_0000_0000);
    send_item(OP_APPLY, 10'd5, POS_LIMIT);
    send_item(OP_APPLY, 10'd6, 64'h0000_0003_0000_0000);
    send_item(OP_APPLY, 10'd8, 64'd0);
    send_item(OP_APPLY, 10'd4, 64'h0123_4567_89AB_CDEF);
    send_item(OP_APPLY, 10'd7, '1);
    send_item(OP_APPLY, 10'd10, 64'hFFFF_FFFF_8000_0000);
    settle();

    run_segment(14, 55, 64'd0, POS_LIMIT, 1'b0);
    // top bit of the threshold write must be dropped
    run_segment(14, 55, '1, NEG_LIMIT, 1'b0);
    run_segment(55, 14, 64'h0000_0001_0000_0000, {$urandom, $urandom}, 1'b0);
    run_segment(55, 14, {1'b1, 31'd0, $urandom}, 64'd0, 1'b0);
    run_segment(0, 0, {1'b0, THRESHOLD_RESET}, 64'hFFFF_FFFF_0000_0000, 1'b1);
    run_segment(0, 0, {$urandom, $urandom} >> $urandom_range(0, 63),
                {$urandom, $urandom}, 1'b0);

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
